[hdl/bpad_pkg.sv]
// Shared types and constants for the PKCS#7 block padder and unpadder.
// No dependencies; every other file of the block imports this package.
package bpad_pkg;

  localparam int MAX_BLOCK_DEFAULT = 64;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] BLK_LEN_RESET = 7'd16;

  // Register indexes on the configuration port.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BLK_LEN   = 1'b0;
  localparam cfg_idx_t CFG_DIRECTION = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ENC_DATA,
    CMD_ENC_END,
    CMD_DEC_DATA,
    CMD_DEC_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

[hdl/bpad_front.sv]
// Front end: accepts input words and classifies them into queue commands.
// Depends on bpad_pkg.
module bpad_front import bpad_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              direction_i,
  output logic              push_o,
  output cmd_t              push_cmd_o,
  input  logic              push_ready_i
);

  cmd_kind_e kind;

  always_comb begin
    if (direction_i == DIR_DECODE) begin
      kind = (op_i == OP_END) ? CMD_DEC_END : CMD_DEC_DATA;
    end else begin
      kind = (op_i == OP_END) ? CMD_ENC_END : CMD_ENC_DATA;
    end
  end

  assign in_ready_o      = push_ready_i;
  assign push_o          = in_valid_i & push_ready_i;
  assign push_cmd_o.kind = kind;
  assign push_cmd_o.data = data_byte_i;

endmodule

[hdl/bpad_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on bpad_pkg.
module bpad_queue import bpad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[hdl/bpad_back.sv]
// Back end: executes queued commands, owns the block store and the output register.
// Depends on bpad_pkg.
module bpad_back import bpad_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CFG_W-1:0]  blk_len_i,
  input  logic              head_valid_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              byte_valid_o,
  output logic              last_o,
  output logic              bad_padding_o
);

  localparam int PW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_EPAD,
    S_DPAD,
    S_DCHK,
    S_DERR,
    S_DSTAT
  } state_e;

  state_e            state_q, state_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [PW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     keep_q, keep_d;
  logic [BYTE_W-1:0] pad_q, pad_d;
  logic              emit_end_q, emit_end_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              byte_valid_q, byte_valid_d;
  logic              last_q, last_d;
  logic              bad_q, bad_d;

  logic [BYTE_W-1:0] mem [MAX_BLOCK];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;

  logic [CW-1:0]     bs;
  logic [CW-1:0]     pos_ext, pos_inc, pos_sub, fill_m1, idx_inc;
  logic              can_load, load, emit_done;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_bv, ld_last, ld_bad;

  // Block size as used: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    if (blk_len_i == '0) begin
      bs = CW'(1);
    end else if (blk_len_i > CFG_W'(MAX_BLOCK)) begin
      bs = CW'(MAX_BLOCK);
    end else begin
      bs = blk_len_i[CW-1:0];
    end
  end

  assign can_load  = !out_valid_q || out_ready_i;
  assign pos_ext   = CW'(pos_q);
  assign pos_inc   = pos_ext + 1'b1;
  assign pos_sub   = pos_ext - bs;
  assign fill_m1   = fill_q - 1'b1;
  assign idx_inc   = CW'(idx_q) + 1'b1;
  assign emit_done = (idx_inc == cnt_q);

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    keep_d     = keep_q;
    pad_d      = pad_q;
    emit_end_d = emit_end_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = fill_q[PW-1:0];
    load       = 1'b0;
    ld_byte    = '0;
    ld_bv      = 1'b0;
    ld_last    = 1'b0;
    ld_bad     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            CMD_ENC_DATA: begin
              if (pos_ext >= bs) begin
                pos_d = pos_sub[PW-1:0];
              end else if (can_load) begin
                load    = 1'b1;
                ld_byte = head_i.data;
                ld_bv   = 1'b1;
                pos_d   = (pos_inc == bs) ? '0 : pos_inc[PW-1:0];
                pop_o   = 1'b1;
              end
            end
            CMD_ENC_END: begin
              if (pos_ext >= bs) begin
                pos_d = pos_sub[PW-1:0];
              end else begin
                pad_d   = BYTE_W'(bs - pos_ext);
                cnt_d   = '0;
                state_d = S_EPAD;
              end
            end
            CMD_DEC_DATA: begin
              if (fill_q >= bs) begin
                idx_d      = '0;
                cnt_d      = fill_q;
                emit_end_d = 1'b0;
                state_d    = S_EMIT;
              end else begin
                mem_we = 1'b1;
                fill_d = fill_q + 1'b1;
                pop_o  = 1'b1;
              end
            end
            CMD_DEC_END: begin
              if (fill_q == '0 || fill_q != bs) begin
                state_d = S_DERR;
              end else begin
                idx_d   = fill_m1[PW-1:0];
                state_d = S_DPAD;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      S_EPAD: begin
        if (can_load) begin
          load    = 1'b1;
          ld_byte = pad_q;
          ld_bv   = 1'b1;
          ld_last = ((BYTE_W'(cnt_q) + 1'b1) == pad_q);
          if (ld_last) begin
            pos_d   = '0;
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_DPAD: begin
        pad_d  = rdata_q;
        keep_d = fill_q - rdata_q[CW-1:0];
        if (rdata_q == '0 || rdata_q > BYTE_W'(bs)) begin
          state_d = S_DERR;
        end else begin
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        if (rdata_q != pad_q) begin
          state_d = S_DERR;
        end else if (CW'(idx_q) == keep_q) begin
          if (keep_q == '0) begin
            state_d = S_DSTAT;
          end else begin
            idx_d      = '0;
            cnt_d      = keep_q;
            emit_end_d = 1'b1;
            state_d    = S_EMIT;
          end
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      S_DERR: begin
        if (can_load) begin
          load    = 1'b1;
          ld_last = 1'b1;
          ld_bad  = 1'b1;
          fill_d  = '0;
          pop_o   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DSTAT: begin
        if (can_load) begin
          load    = 1'b1;
          ld_last = 1'b1;
          fill_d  = '0;
          pop_o   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          load    = 1'b1;
          ld_byte = rdata_q;
          ld_bv   = 1'b1;
          ld_last = emit_end_q & emit_done;
          if (emit_done) begin
            if (emit_end_q) begin
              fill_d = '0;
            end else begin
              // The data word that released the block becomes the first of the next one.
              mem_we    = 1'b1;
              mem_waddr = '0;
              fill_d    = CW'(1);
            end
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_inc[PW-1:0];
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d  = out_valid_q & ~out_ready_i;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    last_d       = last_q;
    bad_d        = bad_q;
    if (load) begin
      out_valid_d  = 1'b1;
      out_byte_d   = ld_byte;
      byte_valid_d = ld_bv;
      last_d       = ld_last;
      bad_d        = ld_bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pos_q        <= '0;
      fill_q       <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      keep_q       <= '0;
      pad_q        <= '0;
      emit_end_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      byte_valid_q <= 1'b0;
      last_q       <= 1'b0;
      bad_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      fill_q       <= fill_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      keep_q       <= keep_d;
      pad_q        <= pad_d;
      emit_end_q   <= emit_end_d;
      out_valid_q  <= out_valid_d;
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      last_q       <= last_d;
      bad_q        <= bad_d;
    end
  end

  // Block store: the read follows the next index; rdata_q holds pre-write mem[idx_q].
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= head_i.data;
    end
    rdata_q <= mem[idx_d];
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign last_o        = last_q;
  assign bad_padding_o = bad_q;

endmodule

[hdl/block_pad_encode_decode.sv]
// Top level of the PKCS#7 block padder and unpadder: configuration registers and wiring.
// Depends on bpad_pkg, bpad_front, bpad_queue and bpad_back.
//
// This block adds or strips PKCS#7 padding on a byte stream. Each input word is either a
// data byte (op 0) or an end-of-message mark (op 1). With direction 0 every data byte
// passes straight through and the block counts its position in the cipher block; the
// end mark produces 1 to block-length pad bytes, each equal to the pad length, so an
// aligned message gets a full block of padding. With direction 1 data bytes collect in a
// one-block store, and a full block is released only when another data byte arrives.
// At the end mark the store must hold exactly one block of bytes and end in a valid pad;
// the block then emits the unpadded bytes, a single status word with no byte when the
// whole block was padding, or a single word with bad_padding set. The final word of a
// message carries last. Each direction keeps its own message state. A block length of 0
// acts as 1, and a value above MAX_BLOCK acts as MAX_BLOCK. Configuration is to be
// written by the user only while the block is idle; the block itself does not enforce
// it. A front end classifies input words into a two-entry command queue, and a back end
// executes them and drives a registered output, so input is taken while output is
// stalled until the queue is full. An encode end mark first sets up the pad length and
// then emits the pad bytes. A decode block is released from the store, whose read port
// supplies one byte a cycle while the output is not stalled. A decode end mark fetches
// the pad byte and checks each pad byte, then emits the kept bytes or the status word;
// an error word follows once a check fails. After the block length was lowered
// mid-message, an encode word first subtracts the block length from the saved position
// until it is below the block length. There is no clearing pass after reset.
module block_pad_encode_decode import bpad_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  cfg_idx_t          cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              byte_valid_o,
  output logic              last_o,
  output logic              bad_padding_o
);

  logic [CFG_W-1:0] blk_len_q;
  logic             direction_q;

  logic             push;
  cmd_t             push_cmd;
  logic             push_ready;
  logic             pop;
  logic             head_valid;
  cmd_t             head;

  // Configuration registers; a write to an index is taken in the cycle it is presented.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len_q   <= BLK_LEN_RESET;
      direction_q <= DIR_ENCODE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BLK_LEN: begin
          blk_len_q <= cfg_wdata_i;
        end
        CFG_DIRECTION: begin
          direction_q <= cfg_wdata_i[0];
        end
        default: begin
          blk_len_q <= blk_len_q;
        end
      endcase
    end
  end

  // The front end tags each word with the direction it was accepted under.
  bpad_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .direction_i  (direction_q),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  bpad_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The back end owns the encode position, the decode store and the output register.
  bpad_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .blk_len_i     (blk_len_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .bad_padding_o (bad_padding_o)
  );

endmodule

[dv/block_pad_encode_decode_tb.sv]
// Self-checking testbench for the PKCS#7 block padder and unpadder.
// Holds its own padding predictor, a directed table and random message traffic.
// Depends on bpad_pkg and block_pad_encode_decode.
module block_pad_encode_decode_tb;
  import bpad_pkg::*;

  // The watchdog must outlast the long receiver hold-off, the settle pause
  // before register writes and the slowest decode end mark.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles left after the last expected word before a register write. A decode
  // data byte gives no word, and a release or an end check runs on in the back
  // end, so this leaves a good margin.
  localparam int SETTLE_CYCLES  = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int SEG_WORDS      = 18;
  localparam int MAXB           = MAX_BLOCK_DEFAULT;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              bad_padding;
  } pad_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  // One row of the directed table. A ROW_CFG row writes value to register idx.
  // A ROW_WORD row sends one input word; when typed is set, the single word it
  // causes is expected to equal res.
  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_t          idx;
    logic              op;
    logic [BYTE_W-1:0] value;
    logic              typed;
    pad_result_t       res;
  } stim_row_t;

  localparam pad_result_t NO_RES     = '0;
  localparam pad_result_t ERR_RES    = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam pad_result_t STATUS_RES = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam pad_result_t PAD1_RES   = '{8'h01, 1'b1, 1'b1, 1'b0};

  // Directed part. It starts in encode mode with the reset block size of 16.
  stim_row_t directed_rows [35] = '{
    // Encode: pass-through, short pad, a whole pad block for an empty message.
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b0, NO_RES},
    // A block size of 0 acts as 1, so every end mark gives one pad byte.
    '{ROW_CFG,  CFG_BLK_LEN,   OP_DATA, 8'd0,  1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, PAD1_RES},
    // Oversized block size acts as 64, then is lowered to 2 mid-message.
    '{ROW_CFG,  CFG_BLK_LEN,   OP_DATA, 8'd127, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h5A, 1'b1, '{8'h5A, 1'b1, 1'b0, 1'b0}},
    '{ROW_CFG,  CFG_BLK_LEN,   OP_DATA, 8'd2,  1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, PAD1_RES},
    // Leave an encode message open and switch to decode.
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h11, 1'b1, '{8'h11, 1'b1, 1'b0, 1'b0}},
    '{ROW_CFG,  CFG_DIRECTION, OP_DATA, 8'd1,  1'b0, NO_RES},
    // Decode with block size 2: a block release, then a one-byte pad strip.
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h10, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h20, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h30, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h01, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, '{8'h30, 1'b1, 1'b1, 1'b0}},
    // A final block that is all padding gives one status word.
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h02, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h02, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, STATUS_RES},
    // Mismatching pad byte, short block and empty message are all errors.
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h01, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h02, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, ERR_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h01, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, ERR_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, ERR_RES},
    // Leave a decode message open; the open encode message must still be there.
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h7E, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_DIRECTION, OP_DATA, 8'd0,  1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, PAD1_RES},
    // Back to decode with a lowered block size: the stored byte is released.
    '{ROW_CFG,  CFG_DIRECTION, OP_DATA, 8'd1,  1'b0, NO_RES},
    '{ROW_CFG,  CFG_BLK_LEN,   OP_DATA, 8'd1,  1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h00, 1'b1, '{8'h7E, 1'b1, 1'b0, 1'b0}},
    // Pad length zero and pad length above the block size are errors.
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, ERR_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_DATA, 8'h03, 1'b0, NO_RES},
    '{ROW_WORD, CFG_BLK_LEN,   OP_END,  8'h00, 1'b1, ERR_RES}
  };

  // Random segments: block size and direction for each, four per idling phase.
  logic [CFG_W-1:0] seg_bsize [12] = '{7'd4, 7'd16, 7'd1, 7'd127, 7'd64, 7'd0,
                                      7'd3, 7'd2, 7'd5, 7'd8, 7'd2, 7'd0};
  logic seg_dir [12] = '{DIR_DECODE, DIR_ENCODE, DIR_DECODE, DIR_ENCODE,
                         DIR_DECODE, DIR_ENCODE, DIR_DECODE, DIR_ENCODE,
                         DIR_ENCODE, DIR_DECODE, DIR_DECODE, DIR_DECODE};

  // Block ports. Every input has a known value from time zero.
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_we      = 1'b0;
  cfg_idx_t          cfg_index   = CFG_BLK_LEN;
  logic [CFG_W-1:0]  cfg_wdata   = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic              op          = OP_DATA;
  logic [BYTE_W-1:0] data_byte   = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              last;
  logic              bad_padding;

  // Typed expectation that travels with the word on the input side.
  logic        word_typed = 1'b0;
  pad_result_t word_res   = '0;

  // Predictor state, kept apart for each direction as the block does.
  logic [CFG_W-1:0]  cfg_bsize = BLK_LEN_RESET;
  logic              cfg_dir   = DIR_ENCODE;
  int                enc_pos   = 0;
  int                dec_fill  = 0;
  logic [BYTE_W-1:0] dec_store [MAXB];
  pad_result_t       awaited_out [$];
  pad_result_t       step_out [$];

  // Idling controls and run statistics.
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_req     = 0;
  int hold_done    = 0;
  int hold_left    = 0;
  int accept_total = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int bad_seen     = 0;
  int cfg_writes   = 0;
  int err_count    = 0;

  always #5 clk = ~clk;

  block_pad_encode_decode u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_byte_o    (out_byte),
    .byte_valid_o  (byte_valid),
    .last_o        (last),
    .bad_padding_o (bad_padding)
  );

  // Block size as the block applies it: 0 acts as 1, above 64 acts as 64.
  function automatic int eff_bsize(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > MAXB) begin
      return MAXB;
    end
    return int'(v);
  endfunction

  // Computes the output words that one accepted input word causes, leaving
  // them in step_out, and advances the state of the active direction.
  task automatic pkcs7_step(input logic wop, input logic [BYTE_W-1:0] b);
    int          bs;
    int          pad;
    int          keep;
    bit          bad;
    pad_result_t r;
    bs = eff_bsize(cfg_bsize);
    step_out.delete();
    if (cfg_dir == DIR_ENCODE) begin
      if (wop == OP_DATA) begin
        r = '{b, 1'b1, 1'b0, 1'b0};
        step_out.push_back(r);
        enc_pos = (enc_pos + 1) % bs;
      end else begin
        // An aligned message gets a whole block of padding.
        pad = bs - enc_pos % bs;
        for (int i = 0; i < pad; i++) begin
          r = '{8'(pad), 1'b1, (i == pad - 1), 1'b0};
          step_out.push_back(r);
        end
        enc_pos = 0;
      end
    end else if (wop == OP_DATA) begin
      // A full block leaves only when a further data byte shows it is not the last.
      if (dec_fill >= bs) begin
        for (int i = 0; i < dec_fill; i++) begin
          r = '{dec_store[i], 1'b1, 1'b0, 1'b0};
          step_out.push_back(r);
        end
        dec_fill = 0;
      end
      dec_store[dec_fill] = b;
      dec_fill++;
    end else begin
      // The store must hold exactly one block that ends in a valid pad.
      bad = (dec_fill != bs);
      pad = 0;
      if (!bad) begin
        pad = int'(dec_store[dec_fill - 1]);
        bad = (pad == 0) || (pad > bs);
      end
      if (!bad) begin
        for (int i = dec_fill - pad; i < dec_fill; i++) begin
          if (int'(dec_store[i]) != pad) begin
            bad = 1'b1;
          end
        end
      end
      keep = dec_fill - pad;
      if (bad) begin
        step_out.push_back(ERR_RES);
      end else if (keep == 0) begin
        step_out.push_back(STATUS_RES);
      end else begin
        for (int i = 0; i < keep; i++) begin
          r = '{dec_store[i], 1'b1, (i == keep - 1), 1'b0};
          step_out.push_back(r);
        end
      end
      dec_fill = 0;
    end
  endtask

  // Both handshakes are sampled at the rising edge. An output word at this edge
  // was registered earlier, so it is checked before the words of an input that
  // is accepted at the same edge are queued.
  always @(posedge clk) begin : monitor
    pad_result_t got;
    pad_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_byte, byte_valid, last, bad_padding};
        results_seen++;
        if (bad_padding) begin
          bad_seen++;
        end
        if (awaited_out.size() == 0) begin
          $error("output word with nothing expected: out_byte %02h valid %0b last %0b bad %0b",
                 got.out_byte, got.byte_valid, got.last, got.bad_padding);
          err_count++;
        end else begin
          want = awaited_out.pop_front();
          if (got.out_byte != want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            err_count++;
          end
          if (got.byte_valid != want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
            err_count++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            err_count++;
          end
          if (got.bad_padding != want.bad_padding) begin
            $error("bad_padding: expected %0b, got %0b", want.bad_padding, got.bad_padding);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pkcs7_step(op, data_byte);
        // A typed table row states its single word directly; the predictor
        // still runs so that its state follows the block.
        if (word_typed) begin
          awaited_out.push_back(word_res);
        end else begin
          foreach (step_out[i]) begin
            awaited_out.push_back(step_out[i]);
          end
        end
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        accept_total++;
      end
    end
  end

  // Receiver side. A hold-off request from the main sequence parks ready low
  // until hold_left, loaded from HOLD_CYCLES, runs out, while the sender keeps
  // offering words, so the block fills up and must stall its input.
  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Ends the run when no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    int seen;
    quiet = 0;
    seen  = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (accept_total != seen) begin
        seen  = accept_total;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Offers one input word, after a random gap, and returns at the falling edge
  // after it was accepted. Valid stays high on return so that back-to-back
  // words need no second assignment in the same step.
  task automatic send_word(input logic wop, input logic [BYTE_W-1:0] b,
                           input logic typed, input pad_result_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= wop;
    data_byte  <= b;
    word_typed <= typed;
    word_res   <= res;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    words_sent++;
  endtask

  // Stops offering words, waits for every expected word, then lets the block
  // finish any work that produces no word.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_out.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register and updates the predictor's copy. The enable drops
  // between writes.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == CFG_BLK_LEN) begin
      cfg_bsize = v;
    end else begin
      cfg_dir = v[0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  // One random segment at a fixed setting. Most traffic is complete messages
  // with random content; decode messages are padded correctly unless broken on
  // purpose, and a few bursts of random words are mixed in. The last message
  // is sometimes left open so that the next setting starts mid-message.
  task automatic run_segment(input logic [CFG_W-1:0] bs_set, input logic dir_set,
                             input bit with_hold);
    int                bs;
    int                sent;
    int                kind;
    int                len;
    int                pad;
    int                idx;
    logic [BYTE_W-1:0] msg [$];
    settle();
    write_reg(CFG_BLK_LEN, bs_set);
    write_reg(CFG_DIRECTION, {6'b0, dir_set});
    if (with_hold) begin
      hold_req++;
    end
    bs   = eff_bsize(bs_set);
    sent = 0;
    while (sent < SEG_WORDS) begin
      msg.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(($urandom_range(3) == 0) ? OP_END : OP_DATA, 8'($urandom), 1'b0, NO_RES);
          sent++;
        end
      end else begin
        len = $urandom_range(0, (bs < 20) ? 2 * bs : 40);
        for (int i = 0; i < len; i++) begin
          msg.push_back(8'($urandom));
        end
        if (dir_set == DIR_DECODE) begin
          pad = bs - len % bs;
          repeat (pad) msg.push_back(8'(pad));
          idx = msg.size() - 1;
          if (kind >= 75 && kind < 82) begin
            // One pad byte differs from the pad length.
            idx = $urandom_range(len, msg.size() - 1);
            msg[idx] = msg[idx] ^ 8'($urandom_range(1, 255));
          end else if (kind >= 82 && kind < 88) begin
            msg[idx] = 8'h00;
          end else if (kind >= 88 && kind < 94) begin
            msg[idx] = 8'($urandom_range(bs + 1, 255));
          end else if (kind >= 94) begin
            // One byte short or one byte long.
            if ($urandom_range(1) == 0) begin
              void'(msg.pop_back());
            end else begin
              msg.push_back(8'($urandom));
            end
          end
        end
        foreach (msg[i]) begin
          send_word(OP_DATA, msg[i], 1'b0, NO_RES);
        end
        send_word(OP_END, 8'($urandom), 1'b0, NO_RES);
        sent += msg.size() + 1;
      end
    end
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(OP_DATA, 8'($urandom), 1'b0, NO_RES);
    end
  endtask

  initial begin : main_seq
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Three idling phases: a mostly stalled receiver, then a mostly idle sender,
    // then full rate on both sides. The directed table runs in the first one.
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 13 : (p == 1) ? 67 : 0;
      rx_idle_pct = (p == 0) ? 67 : (p == 1) ? 13 : 0;
      if (p == 0) begin
        foreach (directed_rows[i]) begin
          if (directed_rows[i].kind == ROW_CFG) begin
            settle();
            write_reg(directed_rows[i].idx, directed_rows[i].value[CFG_W-1:0]);
          end else begin
            send_word(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].res);
          end
        end
      end
      for (int s = 0; s < 4; s++) begin
        run_segment(seg_bsize[4 * p + s], seg_dir[4 * p + s], (4 * p + s) == 5);
      end
    end

    settle();
    $display("Sent %0d input words and checked %0d output words, %0d of them bad padding.",
             words_sent, results_seen, bad_seen);
    $display("Both directions ran at %0d register settings, block sizes 0 to 127.",
             cfg_writes);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
